/* hw/rtl/lbna_pkg.sv */
// ----------------------------------------------------------------------------
// lbna_pkg
// Shared constants, codes and tables of the LOS bearing to NED accel block.
// ----------------------------------------------------------------------------
`default_nettype none

package lbna_pkg;

	// input item codes
	localparam logic OP_ATTITUDE = 1'b0;
	localparam logic OP_BEARING  = 1'b1;

	// register index, taken from paddr[2]
	localparam logic REG_GIMBAL_PITCH = 1'b0;
	localparam logic REG_ACCEL_LIMIT  = 1'b1;

	localparam logic signed [15:0] GIMBAL_RESET = 16'sd0;
	localparam logic [14:0]        LIMIT_RESET  = 15'd5120;

	// angles and trig values in Q.28
	localparam logic signed [31:0] ANG_PI          = 32'sd843314857;
	localparam logic signed [31:0] ANG_HALF_PI     = 32'sd421657428;
	localparam logic signed [31:0] CORDIC_PRESCALE = 32'sd163008219;

	// 1e-6 in the Q.48 vector scale
	localparam logic [31:0] NORM_MIN = 32'd281474977;

	// arctangent of 2^-i in Q.28
	function automatic logic signed [31:0] atan_entry(input logic [4:0] idx);
		logic signed [31:0] v;
		case (idx)
			5'd0:    v = 32'sd210828714;
			5'd1:    v = 32'sd124459457;
			5'd2:    v = 32'sd65760959;
			5'd3:    v = 32'sd33381290;
			5'd4:    v = 32'sd16755422;
			5'd5:    v = 32'sd8385879;
			5'd6:    v = 32'sd4193963;
			5'd7:    v = 32'sd2097109;
			5'd8:    v = 32'sd1048571;
			5'd9:    v = 32'sd524287;
			5'd10:   v = 32'sd262144;
			5'd11:   v = 32'sd131072;
			5'd12:   v = 32'sd65536;
			5'd13:   v = 32'sd32768;
			5'd14:   v = 32'sd16384;
			5'd15:   v = 32'sd8192;
			5'd16:   v = 32'sd4096;
			5'd17:   v = 32'sd2048;
			5'd18:   v = 32'sd1024;
			5'd19:   v = 32'sd512;
			5'd20:   v = 32'sd256;
			5'd21:   v = 32'sd128;
			5'd22:   v = 32'sd64;
			5'd23:   v = 32'sd32;
			default: v = 32'sd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/lbna_cordic.sv */
// ----------------------------------------------------------------------------
// lbna_cordic
// Iterative rotation CORDIC: one micro-rotation a cycle, cos and sin in Q.28.
// ----------------------------------------------------------------------------
`default_nettype none

module lbna_cordic #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [15:0] angle,
	output logic                    done,
	output logic signed [31:0]      cos_out,
	output logic signed [31:0]      sin_out
);

	localparam logic [4:0] LAST = 5'(CORDIC_STEPS - 1);

	logic               busy_q;
	logic               done_q;
	logic [4:0]         i_q;
	logic               flip_q;
	logic signed [31:0] x_q, y_q, z_q;

	logic signed [31:0] z0, z_init, dx, dy, at;
	logic               flip_init;

	always_comb begin
		z0        = {angle[15], angle, 15'b0};
		z_init    = z0;
		flip_init = 1'b0;
		if (z0 > lbna_pkg::ANG_HALF_PI) begin
			z_init    = z0 - lbna_pkg::ANG_PI;
			flip_init = 1'b1;
		end else if (z0 < -lbna_pkg::ANG_HALF_PI) begin
			z_init    = z0 + lbna_pkg::ANG_PI;
			flip_init = 1'b1;
		end
		dx = y_q >>> i_q;
		dy = x_q >>> i_q;
		at = lbna_pkg::atan_entry(i_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				if (i_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					i_q <= i_q + 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= lbna_pkg::CORDIC_PRESCALE;
			y_q    <= '0;
			z_q    <= z_init;
			flip_q <= flip_init;
		end else if (busy_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	assign done    = done_q;
	assign cos_out = flip_q ? -x_q : x_q;
	assign sin_out = flip_q ? -y_q : y_q;

endmodule

`default_nettype wire

/* hw/rtl/lbna_isqrt.sv */
// ----------------------------------------------------------------------------
// lbna_isqrt
// Integer square root, digit by digit, two radicand bits a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lbna_isqrt (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] radicand,
	output logic             done,
	output logic [31:0]      root
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  k_q;
	logic [63:0] v_q, r_q;

	logic [63:0] bitv, trial;

	assign bitv  = 64'd1 << {k_q, 1'b0};
	assign trial = r_q + bitv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				k_q    <= 5'd31;
			end else if (busy_q) begin
				k_q <= k_q - 5'd1;
				if (k_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= radicand;
			r_q <= '0;
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + bitv;
			end else begin
				r_q <= r_q >> 1;
			end
		end
	end

	assign done = done_q;
	assign root = r_q[31:0];

endmodule

`default_nettype wire

/* hw/rtl/lbna_div.sv */
// ----------------------------------------------------------------------------
// lbna_div
// Scale one axis: round(limit * n / norm) half away from zero, saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module lbna_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [31:0] num_in,
	input  wire logic [14:0]        limit,
	input  wire logic [31:0]        norm,
	output logic                    done,
	output logic signed [15:0]      value
);

	typedef enum logic [3:0] {
		D_IDLE = 4'b0001,
		D_ADD  = 4'b0010,
		D_CHK  = 4'b0100,
		D_ITER = 4'b1000
	} div_state_t;

	div_state_t  st_q;
	logic        done_q;
	logic [3:0]  cnt_q;
	logic        neg_q;
	logic [45:0] prod_q;
	logic [47:0] rem_q, dsor_q;
	logic [16:0] q_q;

	logic [31:0] num_mag;
	logic [47:0] top_dsor;
	logic [16:0] qc;

	assign num_mag  = num_in[31] ? 32'(-num_in) : 32'(num_in);
	assign top_dsor = 48'(norm) << 16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= D_IDLE;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				D_IDLE: if (start) st_q <= D_ADD;
				D_ADD:  st_q <= D_CHK;
				D_CHK: begin
					if (rem_q >= top_dsor) begin
						st_q   <= D_IDLE;
						done_q <= 1'b1;
					end else begin
						st_q  <= D_ITER;
						cnt_q <= 4'd15;
					end
				end
				D_ITER: begin
					cnt_q <= cnt_q - 4'd1;
					if (cnt_q == 4'd0) begin
						st_q   <= D_IDLE;
						done_q <= 1'b1;
					end
				end
				default: st_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			D_IDLE: if (start) begin
				prod_q <= num_mag[30:0] * limit;
				neg_q  <= num_in[31];
			end
			D_ADD: rem_q <= 48'(prod_q) + 48'(norm >> 1);
			D_CHK: begin
				// quotient of 2^16 or more saturates anyway
				q_q    <= (rem_q >= top_dsor) ? 17'h10000 : 17'd0;
				dsor_q <= 48'(norm) << 15;
			end
			D_ITER: begin
				if (rem_q >= dsor_q) begin
					rem_q <= rem_q - dsor_q;
					q_q   <= {q_q[15:0], 1'b1};
				end else begin
					q_q <= {q_q[15:0], 1'b0};
				end
				dsor_q <= dsor_q >> 1;
			end
			default: ;
		endcase
	end

	always_comb begin
		qc = (q_q > 17'd32768) ? 17'd32768 : q_q;
		if (neg_q)
			value = 16'(17'd0 - qc);
		else if (qc > 17'd32767)
			value = 16'sd32767;
		else
			value = 16'(qc);
	end

	assign done = done_q;

endmodule

`default_nettype wire

/* hw/rtl/los_bearing_to_ned_accel_top.sv */
// ----------------------------------------------------------------------------
// los_bearing_to_ned_accel_top
// Bearing to yaw rate, servo command and NED acceleration command.
// ----------------------------------------------------------------------------
// Items enter on in_valid/in_ready; a transfer with opcode 0 stores the
// attitude quaternion and gives no result. A transfer with opcode 1 gives
// one result on out_valid/out_ready: yaw rate, servo command and, once an
// attitude is held and the vector is not too short, the normalized
// acceleration vector. A bearing item runs the shared CORDIC for azimuth,
// elevation and gimbal pitch, then the single multiply-accumulate unit, the
// normalizing shifts, the square root and the serial divider for each axis.
// Without attitude the sequencer goes from the transfer straight to its
// final state, which loads the output register, and for a too short vector
// it goes there from the check after the square root.
// in_ready is high only while the sequencer is idle. The result sits in an
// output register; the next item is taken while it waits, and its own
// result waits until the old one is transferred.
// Reset clears the attitude, the output valid and the sequencer, and sets
// gimbal_pitch to 0 and accel_limit to 5120 (APB at 0x0 and 0x4).
// ----------------------------------------------------------------------------
`default_nettype none

module los_bearing_to_ned_accel_top #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               opcode,
	input  wire logic signed [15:0] azimuth,
	input  wire logic signed [15:0] elevation,
	input  wire logic signed [15:0] quat_w,
	input  wire logic signed [15:0] quat_x,
	input  wire logic signed [15:0] quat_y,
	input  wire logic signed [15:0] quat_z,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [15:0]      yaw_rate,
	output logic signed [15:0]      servo_cmd,
	output logic                    accel_valid,
	output logic signed [15:0]      accel_north,
	output logic signed [15:0]      accel_east,
	output logic signed [15:0]      accel_down
);

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_CORDIC = 9'b000000010,
		ST_MAC    = 9'b000000100,
		ST_SHINIT = 9'b000001000,
		ST_SHIFT  = 9'b000010000,
		ST_SQRT   = 9'b000100000,
		ST_CHECK  = 9'b001000000,
		ST_DIV    = 9'b010000000,
		ST_FIN    = 9'b100000000
	} seq_state_t;

	typedef enum logic [1:0] {
		M_LOAD = 2'd0,
		M_ADD  = 2'd1,
		M_SUB  = 2'd2
	} mac_mode_t;

	typedef enum logic [3:0] {
		W_NONE = 4'd0,
		W_G0   = 4'd1,
		W_G1   = 4'd2,
		W_B0   = 4'd3,
		W_B2   = 4'd4,
		W_QP   = 4'd5,
		W_N0   = 4'd6,
		W_N1   = 4'd7,
		W_N2   = 4'd8,
		W_SUM  = 4'd9
	} mac_dst_t;

	localparam logic [4:0] PC_QP_FIRST = 5'd6;
	localparam logic [4:0] PC_VEC_END  = 5'd24;
	localparam logic [4:0] PC_SQ_FIRST = 5'd25;
	localparam logic [4:0] PC_SQ_END   = 5'd27;

	// control
	seq_state_t state_q;
	logic       out_valid_q;
	logic       known_q;
	logic [4:0] pc_q;
	logic       ph_q;
	logic [1:0] idx_q;
	logic [5:0] s_q;
	logic       cord_go_q, sqrt_go_q, div_go_q;
	logic signed [15:0] gimbal_q;
	logic [14:0]        limit_q;
	logic signed [15:0] quat_q [4];

	// datapath
	logic signed [15:0] az_q, el_q;
	logic signed [31:0] ca_q, sa_q, cb_q, sb_q, cp_q, sp_q, g0_q;
	logic signed [23:0] b0_q, b1_q, b2_q;
	logic signed [31:0] qp_q [10];
	logic signed [63:0] n_q [3];
	logic [63:0]        sum_q, mx_q;
	logic [31:0]        norm_q;
	logic signed [66:0] prod_q;
	logic signed [67:0] acc_q;
	logic signed [15:0] res_q [3];
	logic               res_ok_q;
	logic signed [15:0] yaw_q, servo_q, an_q, ae_q, ad_q;
	logic               av_q;

	logic               in_fire, cfg_wr, out_load, chk_bad;
	logic signed [15:0] cord_angle;
	logic               cord_done, sqrt_done, div_done;
	logic signed [31:0] cord_cos, cord_sin, g2;
	logic [31:0]        sqrt_root;
	logic signed [15:0] div_val;
	logic signed [34:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	logic signed [34:0] mac_a;
	logic signed [31:0] mac_b;
	mac_mode_t          mac_mode;
	mac_dst_t           mac_dst;
	logic signed [67:0] acc_nxt;
	logic [3:0]         qp_idx;
	logic [63:0]        mag0, mag1, mag2, mx_init;
	logic [65:0]        norm_scaled;
	logic signed [18:0] yaw_sum;
	logic signed [15:0] yaw_w, servo_w;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign cfg_wr   = psel && penable && pwrite;
	assign out_load = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	assign pready   = 1'b1;

	always_comb begin
		case (paddr[2])
			lbna_pkg::REG_GIMBAL_PITCH: prdata = {16'b0, gimbal_q};
			lbna_pkg::REG_ACCEL_LIMIT:  prdata = {17'b0, limit_q};
			default:                    prdata = '0;
		endcase
	end

	// shared units
	always_comb begin
		case (idx_q)
			2'd0:    cord_angle = az_q;
			2'd1:    cord_angle = el_q;
			default: cord_angle = gimbal_q;
		endcase
	end

	lbna_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cord_go_q), .angle(cord_angle),
		.done(cord_done), .cos_out(cord_cos), .sin_out(cord_sin)
	);

	lbna_isqrt u_isqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_go_q), .radicand(sum_q),
		.done(sqrt_done), .root(sqrt_root)
	);

	lbna_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go_q),
		.num_in($signed(n_q[idx_q][31:0])), .limit(limit_q), .norm(norm_q),
		.done(div_done), .value(div_val)
	);

	// rotation matrix of q, unnormalized, from the ten stored products
	// qp order: ww xx yy zz xy wz xz wy yz wx
	always_comb begin
		m00 = 35'(qp_q[0]) + 35'(qp_q[1]) - 35'(qp_q[2]) - 35'(qp_q[3]);
		m11 = 35'(qp_q[0]) - 35'(qp_q[1]) + 35'(qp_q[2]) - 35'(qp_q[3]);
		m22 = 35'(qp_q[0]) - 35'(qp_q[1]) - 35'(qp_q[2]) + 35'(qp_q[3]);
		m01 = (35'(qp_q[4]) - 35'(qp_q[5])) <<< 1;
		m10 = (35'(qp_q[4]) + 35'(qp_q[5])) <<< 1;
		m02 = (35'(qp_q[6]) + 35'(qp_q[7])) <<< 1;
		m20 = (35'(qp_q[6]) - 35'(qp_q[7])) <<< 1;
		m12 = (35'(qp_q[8]) - 35'(qp_q[9])) <<< 1;
		m21 = (35'(qp_q[8]) + 35'(qp_q[9])) <<< 1;
		g2  = -sb_q;
	end

	// multiply-accumulate program
	always_comb begin
		mac_a    = '0;
		mac_b    = '0;
		mac_mode = M_LOAD;
		mac_dst  = W_NONE;
		case (pc_q)
			5'd0:  begin mac_a = 35'(ca_q); mac_b = cb_q; mac_dst = W_G0; end
			5'd1:  begin mac_a = 35'(sa_q); mac_b = cb_q; mac_dst = W_G1; end
			5'd2:  begin mac_a = 35'(cp_q); mac_b = g0_q; end
			5'd3:  begin
				mac_a = 35'(sp_q); mac_b = g2; mac_mode = M_ADD; mac_dst = W_B0;
			end
			5'd4:  begin mac_a = 35'(cp_q); mac_b = g2; end
			5'd5:  begin
				mac_a = 35'(sp_q); mac_b = g0_q; mac_mode = M_SUB; mac_dst = W_B2;
			end
			5'd6:  begin mac_a = 35'(quat_q[0]); mac_b = 32'(quat_q[0]); mac_dst = W_QP; end
			5'd7:  begin mac_a = 35'(quat_q[1]); mac_b = 32'(quat_q[1]); mac_dst = W_QP; end
			5'd8:  begin mac_a = 35'(quat_q[2]); mac_b = 32'(quat_q[2]); mac_dst = W_QP; end
			5'd9:  begin mac_a = 35'(quat_q[3]); mac_b = 32'(quat_q[3]); mac_dst = W_QP; end
			5'd10: begin mac_a = 35'(quat_q[1]); mac_b = 32'(quat_q[2]); mac_dst = W_QP; end
			5'd11: begin mac_a = 35'(quat_q[0]); mac_b = 32'(quat_q[3]); mac_dst = W_QP; end
			5'd12: begin mac_a = 35'(quat_q[1]); mac_b = 32'(quat_q[3]); mac_dst = W_QP; end
			5'd13: begin mac_a = 35'(quat_q[0]); mac_b = 32'(quat_q[2]); mac_dst = W_QP; end
			5'd14: begin mac_a = 35'(quat_q[2]); mac_b = 32'(quat_q[3]); mac_dst = W_QP; end
			5'd15: begin mac_a = 35'(quat_q[0]); mac_b = 32'(quat_q[1]); mac_dst = W_QP; end
			5'd16: begin mac_a = m00; mac_b = 32'(b0_q); end
			5'd17: begin mac_a = m01; mac_b = 32'(b1_q); mac_mode = M_ADD; end
			5'd18: begin mac_a = m02; mac_b = 32'(b2_q); mac_mode = M_ADD; mac_dst = W_N0; end
			5'd19: begin mac_a = m10; mac_b = 32'(b0_q); end
			5'd20: begin mac_a = m11; mac_b = 32'(b1_q); mac_mode = M_ADD; end
			5'd21: begin mac_a = m12; mac_b = 32'(b2_q); mac_mode = M_ADD; mac_dst = W_N1; end
			5'd22: begin mac_a = m20; mac_b = 32'(b0_q); end
			5'd23: begin mac_a = m21; mac_b = 32'(b1_q); mac_mode = M_ADD; end
			5'd24: begin mac_a = m22; mac_b = 32'(b2_q); mac_mode = M_ADD; mac_dst = W_N2; end
			5'd25: begin
				mac_a = $signed(n_q[0][34:0]); mac_b = $signed(n_q[0][31:0]);
			end
			5'd26: begin
				mac_a = $signed(n_q[1][34:0]); mac_b = $signed(n_q[1][31:0]);
				mac_mode = M_ADD;
			end
			5'd27: begin
				mac_a = $signed(n_q[2][34:0]); mac_b = $signed(n_q[2][31:0]);
				mac_mode = M_ADD; mac_dst = W_SUM;
			end
			default: ;
		endcase
		case (mac_mode)
			M_ADD:   acc_nxt = acc_q + 68'(prod_q);
			M_SUB:   acc_nxt = acc_q - 68'(prod_q);
			default: acc_nxt = 68'(prod_q);
		endcase
		qp_idx = 4'(pc_q - PC_QP_FIRST);
	end

	always_comb begin
		mag0    = n_q[0][63] ? 64'(-n_q[0]) : 64'(n_q[0]);
		mag1    = n_q[1][63] ? 64'(-n_q[1]) : 64'(n_q[1]);
		mag2    = n_q[2][63] ? 64'(-n_q[2]) : 64'(n_q[2]);
		mx_init = mag0;
		if (mag1 > mx_init) mx_init = mag1;
		if (mag2 > mx_init) mx_init = mag2;
		norm_scaled = 66'(norm_q) << s_q;
		chk_bad     = (norm_q == 32'd0) || (norm_scaled < 66'(lbna_pkg::NORM_MIN));
		yaw_sum     = (19'(az_q) <<< 1) + 19'(az_q) + 19'sd2;
		yaw_w       = 16'(yaw_sum >>> 2);
		if (el_q > 16'sd16384)
			servo_w = 16'sd16384;
		else if (el_q < -16'sd16384)
			servo_w = -16'sd16384;
		else
			servo_w = el_q;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			known_q     <= 1'b0;
			pc_q        <= '0;
			ph_q        <= 1'b0;
			idx_q       <= '0;
			s_q         <= '0;
			cord_go_q   <= 1'b0;
			sqrt_go_q   <= 1'b0;
			div_go_q    <= 1'b0;
			gimbal_q    <= lbna_pkg::GIMBAL_RESET;
			limit_q     <= lbna_pkg::LIMIT_RESET;
			for (int k = 0; k < 4; k++) quat_q[k] <= '0;
		end else begin
			cord_go_q <= 1'b0;
			sqrt_go_q <= 1'b0;
			div_go_q  <= 1'b0;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (cfg_wr) begin
				case (paddr[2])
					lbna_pkg::REG_GIMBAL_PITCH: gimbal_q <= pwdata[15:0];
					lbna_pkg::REG_ACCEL_LIMIT:  limit_q  <= pwdata[14:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: if (in_fire) begin
					if (opcode == lbna_pkg::OP_ATTITUDE) begin
						quat_q[0] <= quat_w;
						quat_q[1] <= quat_x;
						quat_q[2] <= quat_y;
						quat_q[3] <= quat_z;
						known_q   <= 1'b1;
					end else if (known_q) begin
						state_q   <= ST_CORDIC;
						idx_q     <= 2'd0;
						cord_go_q <= 1'b1;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_CORDIC: if (cord_done) begin
					if (idx_q == 2'd2) begin
						state_q <= ST_MAC;
						pc_q    <= '0;
						ph_q    <= 1'b0;
					end else begin
						idx_q     <= idx_q + 2'd1;
						cord_go_q <= 1'b1;
					end
				end
				ST_MAC: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						if (pc_q == PC_VEC_END) begin
							state_q <= ST_SHINIT;
						end else if (pc_q == PC_SQ_END) begin
							state_q   <= ST_SQRT;
							sqrt_go_q <= 1'b1;
						end else begin
							pc_q <= pc_q + 5'd1;
						end
					end
				end
				ST_SHINIT: begin
					state_q <= ST_SHIFT;
					s_q     <= '0;
				end
				ST_SHIFT: begin
					if (|mx_q[63:30]) begin
						s_q <= s_q + 6'd1;
					end else begin
						state_q <= ST_MAC;
						pc_q    <= PC_SQ_FIRST;
						ph_q    <= 1'b0;
					end
				end
				ST_SQRT: if (sqrt_done) state_q <= ST_CHECK;
				ST_CHECK: begin
					if (chk_bad) begin
						state_q <= ST_FIN;
					end else begin
						state_q  <= ST_DIV;
						idx_q    <= 2'd0;
						div_go_q <= 1'b1;
					end
				end
				ST_DIV: if (div_done) begin
					if (idx_q == 2'd2) begin
						state_q <= ST_FIN;
					end else begin
						idx_q    <= idx_q + 2'd1;
						div_go_q <= 1'b1;
					end
				end
				ST_FIN: if (out_load) begin
					state_q     <= ST_IDLE;
					out_valid_q <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (in_fire) begin
				az_q     <= azimuth;
				el_q     <= elevation;
				res_ok_q <= 1'b0;
				for (int k = 0; k < 3; k++) res_q[k] <= '0;
			end
			ST_CORDIC: if (cord_done) begin
				case (idx_q)
					2'd0: begin ca_q <= cord_cos; sa_q <= cord_sin; end
					2'd1: begin cb_q <= cord_cos; sb_q <= cord_sin; end
					default: begin cp_q <= cord_cos; sp_q <= cord_sin; end
				endcase
			end
			ST_MAC: begin
				if (!ph_q) begin
					prod_q <= mac_a * mac_b;
				end else begin
					acc_q <= acc_nxt;
					case (mac_dst)
						W_G0:  g0_q <= 32'(acc_nxt >>> 28);
						W_G1:  b1_q <= 24'(acc_nxt >>> 36);
						W_B0:  b0_q <= 24'(acc_nxt >>> 36);
						W_B2:  b2_q <= 24'(acc_nxt >>> 36);
						W_QP:  qp_q[qp_idx] <= acc_nxt[31:0];
						W_N0:  n_q[0] <= acc_nxt[63:0];
						W_N1:  n_q[1] <= acc_nxt[63:0];
						W_N2:  n_q[2] <= acc_nxt[63:0];
						W_SUM: sum_q <= acc_nxt[63:0];
						default: ;
					endcase
				end
			end
			ST_SHINIT: mx_q <= mx_init;
			ST_SHIFT: if (|mx_q[63:30]) begin
				// magnitude and values shift apart: floor differs for negatives
				mx_q <= mx_q >> 1;
				for (int k = 0; k < 3; k++) n_q[k] <= n_q[k] >>> 1;
			end
			ST_SQRT: if (sqrt_done) norm_q <= sqrt_root;
			ST_DIV: if (div_done) begin
				res_q[idx_q] <= div_val;
				if (idx_q == 2'd2) res_ok_q <= 1'b1;
			end
			ST_FIN: if (out_load) begin
				yaw_q   <= yaw_w;
				servo_q <= servo_w;
				av_q    <= res_ok_q;
				an_q    <= res_ok_q ? res_q[0] : 16'sd0;
				ae_q    <= res_ok_q ? res_q[1] : 16'sd0;
				ad_q    <= res_ok_q ? res_q[2] : 16'sd0;
			end
			default: ;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign yaw_rate    = yaw_q;
	assign servo_cmd   = servo_q;
	assign accel_valid = av_q;
	assign accel_north = an_q;
	assign accel_east  = ae_q;
	assign accel_down  = ad_q;

endmodule

`default_nettype wire
